// ===== hw/rtl/dssf_pkg.sv =====
// shared types and constants for the decimal seven-segment frame encoder
// segment table, digit-step result struct, widths; no dependencies
`default_nettype none

package dssf_pkg;

    localparam int unsigned VAL_W = 14;
    localparam int unsigned SEG_W = 8;
    localparam int unsigned EN_W  = 4;
    localparam int unsigned POS_W = 2;

    localparam logic [3:0] ERR_INDEX = 4'd10;

    // reciprocal of ten in 16-bit fixed point, exact for values below 10000
    localparam logic [12:0] RECIP_TEN = 13'd6554;

    typedef logic [SEG_W-1:0] t_seg;
    typedef logic [VAL_W-1:0] t_val;

    localparam t_seg SEG_TABLE [11] = '{
        8'h02, 8'h9E, 8'h24, 8'h0C, 8'h98,
        8'h48, 8'h40, 8'h1E, 8'h00, 8'h18,
        8'h60
    };

    typedef struct packed {
        t_val quot;
        t_seg shift_byte;
    } t_dig_res;

    function automatic int unsigned pow10(input int unsigned n);
        int unsigned p;
        p = 1;
        for (int unsigned k = 0; k < n; k++) begin
            p = p * 10;
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dssf_digit.sv =====
// one digit step: splits the low decimal digit off a value and looks up its pattern
// depends on dssf_pkg; with i_err set it looks up the error pattern instead
`default_nettype none

module dssf_digit (
    input  wire dssf_pkg::t_val     i_val,
    input  wire                     i_err,
    output dssf_pkg::t_dig_res      o_res
);
    import dssf_pkg::*;

    logic [VAL_W+12:0] w_prod;
    t_val              w_quot;
    t_val              w_rem;
    logic [3:0]        w_digit;
    logic [3:0]        w_sym;

    always_comb begin
        w_prod  = {13'd0, i_val} * {14'd0, RECIP_TEN};
        w_quot  = VAL_W'(w_prod >> 16);
        w_rem   = i_val - (w_quot << 3) - (w_quot << 1);
        w_digit = w_rem[3:0];
        w_sym   = i_err ? ERR_INDEX : w_digit;
        o_res.quot       = w_quot;
        o_res.shift_byte = ~SEG_TABLE[w_sym];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/decimal_seven_segment_frame_encoder_core.sv =====
// the start word is registered into the sequencer, and each frame is registered from it into the output stage
// throughput: DIGITS frames per value (DIGITS clamped to 1..4), one per cycle; an overflow value gives one frame
// the next start word is taken in the cycle that produces the final frame
// reset: synchronous active low, clears the sequencer and the strobe
// depends on dssf_pkg and dssf_digit
`default_nettype none

module decimal_seven_segment_frame_encoder_core #(
    parameter int DIGITS = 4
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_start,
    output logic                     o_busy,
    input  wire  [15:0]              i_value,
    output logic                     o_valid,
    output logic [dssf_pkg::SEG_W-1:0] o_shift_byte,
    output logic [dssf_pkg::EN_W-1:0]  o_digit_enable,
    output logic                     o_is_error,
    output logic                     o_last
);
    import dssf_pkg::*;

    localparam int unsigned DigN    = (DIGITS < 1) ? 1 : ((DIGITS > 4) ? 4 : DIGITS);
    localparam logic [16:0] Limit   = 17'(pow10(DigN));
    localparam logic [POS_W-1:0] LastPos = POS_W'(DigN - 1);

    logic             r_active, n_active;
    logic             r_err, n_err;
    logic [POS_W-1:0] r_pos, n_pos;
    t_val             r_val, n_val;
    logic             r_valid;
    t_seg             r_shift;
    logic [EN_W-1:0]  r_en;
    logic             r_is_err;
    logic             r_last;

    logic             w_accept;
    logic             w_fin;
    t_dig_res         w_dig;

    dssf_digit u_digit (
        .i_val (r_val),
        .i_err (r_err),
        .o_res (w_dig)
    );

    assign w_fin    = r_active && (r_err || (r_pos == LastPos));
    assign o_busy   = r_active && !w_fin;
    assign w_accept = i_start && !o_busy;

    always_comb begin
        n_active = r_active;
        n_err    = r_err;
        n_pos    = r_pos;
        n_val    = r_val;
        if (w_accept) begin
            n_active = 1'b1;
            n_err    = ({1'b0, i_value} >= Limit);
            n_pos    = '0;
            n_val    = i_value[VAL_W-1:0];
        end else if (w_fin) begin
            n_active = 1'b0;
        end else if (r_active) begin
            n_pos = r_pos + 1'b1;
            n_val = w_dig.quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_err    <= 1'b0;
            r_pos    <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_active <= n_active;
            r_err    <= n_err;
            r_pos    <= n_pos;
            r_valid  <= r_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val    <= n_val;
        r_shift  <= w_dig.shift_byte;
        r_en     <= r_err ? EN_W'(1) : (EN_W'(1) << r_pos);
        r_is_err <= r_err;
        r_last   <= w_fin;
    end

    assign o_valid        = r_valid;
    assign o_shift_byte   = r_shift;
    assign o_digit_enable = r_en;
    assign o_is_error     = r_is_err;
    assign o_last         = r_last;

endmodule

`default_nettype wire

// ===== hw/rtl/dssf_checker.sv =====
// port-level checks for the frame encoder core, bound to the core module
// depends on decimal_seven_segment_frame_encoder_core
`default_nettype none

module dssf_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_start,
    input wire        o_busy,
    input wire        o_valid,
    input wire [3:0]  o_digit_enable,
    input wire        o_is_error,
    input wire        o_last
);

    // a taken word produces its first frame once it has passed the sequencer and output registers
    a_first_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> ##1 o_valid)
        else $error("no frame after start word");

    // frames of one run are contiguous
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> o_valid)
        else $error("gap inside a frame run");

    // overflow frame stands alone on position 0
    a_error_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_error) |-> (o_last && o_digit_enable == 4'b0001))
        else $error("malformed error frame");

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot(o_digit_enable))
        else $error("digit enable not one-hot");

endmodule

bind decimal_seven_segment_frame_encoder_core dssf_checker u_dssf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .o_busy         (o_busy),
    .o_valid        (o_valid),
    .o_digit_enable (o_digit_enable),
    .o_is_error     (o_is_error),
    .o_last         (o_last)
);

`default_nettype wire

// ===== verif/tb_decimal_seven_segment_frame_encoder_core.sv =====
// testbench for decimal_seven_segment_frame_encoder_core: bursty start words in,
// digit frames predicted and checked in order; needs dssf_pkg and the core rtl
`default_nettype none

module tb_decimal_seven_segment_frame_encoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIGITS         = 4;
    localparam int GLYPH_E        = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    localparam logic [7:0] GLYPH [11] = '{
        8'h02, 8'h9E, 8'h24, 8'h0C, 8'h98,
        8'h48, 8'h40, 8'h1E, 8'h00, 8'h18,
        8'h60
    };

    typedef struct packed {
        logic [dssf_pkg::SEG_W-1:0] shift_byte;
        logic [dssf_pkg::EN_W-1:0]  digit_enable;
        logic                       is_error;
        logic                       last;
    } t_frame;

    typedef struct {
        logic [15:0] value;
        bit          drain;
    } t_word;

    logic                       i_clk;
    logic                       i_rst_n = 1'b0;
    logic                       i_start = 1'b0;
    logic [15:0]                i_value = '0;
    logic                       o_busy;
    logic                       o_valid;
    logic [dssf_pkg::SEG_W-1:0] o_shift_byte;
    logic [dssf_pkg::EN_W-1:0]  o_digit_enable;
    logic                       o_is_error;
    logic                       o_last;

    t_word  pending_words[$];
    t_frame frames_due[$];

    bit word_taken = 1'b0;
    int burst_left = 0;
    int gap_left   = 0;
    int idle_count = 0;
    int n_values   = 0;
    int n_overflow = 0;
    int n_frames   = 0;
    int n_errors   = 0;

    decimal_seven_segment_frame_encoder_core #(
        .DIGITS(DIGITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .o_shift_byte  (o_shift_byte),
        .o_digit_enable(o_digit_enable),
        .o_is_error    (o_is_error),
        .o_last        (o_last)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    task automatic queue_digit_frames(input logic [15:0] value);
        int     n;
        int     limit;
        int     rest;
        t_frame f;
        n     = (DIGITS < 1) ? 1 : (DIGITS > 4) ? 4 : DIGITS;
        limit = 1;
        for (int h = 0; h < n; h++) begin
            limit = limit * 10;
        end
        rest = value;
        if (rest >= limit) begin
            f.shift_byte   = ~GLYPH[GLYPH_E];
            f.digit_enable = 4'b0001;
            f.is_error     = 1'b1;
            f.last         = 1'b1;
            frames_due.push_back(f);
            n_overflow++;
        end else begin
            for (int h = 0; h < n; h++) begin
                f.shift_byte   = ~GLYPH[rest % 10];
                f.digit_enable = 4'(1 << h);
                f.is_error     = 1'b0;
                f.last         = (h == n - 1);
                frames_due.push_back(f);
                rest = rest / 10;
            end
        end
    endtask

    task automatic add_word(input logic [15:0] value, input bit drain);
        t_word w;
        w.value = value;
        w.drain = drain;
        pending_words.push_back(w);
    endtask

    // driver: bursts of words separated by random gaps
    always @(negedge i_clk) begin
        bit    go;
        t_word w;
        go = 1'b0;
        if (!i_rst_n) begin
            go = 1'b0;
        end else if (i_start && !word_taken) begin
            go = 1'b1;
        end else if (gap_left > 0) begin
            gap_left--;
            i_value <= 16'($urandom);
        end else if (pending_words.size() > 0 &&
                     !(pending_words[0].drain && frames_due.size() > 0)) begin
            w = pending_words.pop_front();
            go = 1'b1;
            i_value <= w.value;
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 8);
                gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15)
                                                         : $urandom_range(0, 3);
            end
        end else begin
            i_value <= 16'($urandom);
        end
        i_start <= go;
    end

    // monitor: predict on accepted words, check every strobed frame, stop on a watchdog
    always @(posedge i_clk) begin
        t_frame exp_f;
        if (i_rst_n) begin
            word_taken <= i_start && !o_busy;
            if (i_start && !o_busy) begin
                queue_digit_frames(i_value);
                n_values++;
            end
            if (o_valid) begin
                n_frames++;
                if (frames_due.size() == 0) begin
                    $display("%0t: unexpected frame, actual shift_byte %h enable %b err %b last %b",
                             $time, o_shift_byte, o_digit_enable, o_is_error, o_last);
                    n_errors++;
                end else begin
                    exp_f = frames_due.pop_front();
                    if (o_shift_byte !== exp_f.shift_byte) begin
                        $display("%0t: shift_byte expected %h actual %h",
                                 $time, exp_f.shift_byte, o_shift_byte);
                        n_errors++;
                    end
                    if (o_digit_enable !== exp_f.digit_enable) begin
                        $display("%0t: digit_enable expected %b actual %b",
                                 $time, exp_f.digit_enable, o_digit_enable);
                        n_errors++;
                    end
                    if (o_is_error !== exp_f.is_error) begin
                        $display("%0t: is_error expected %b actual %b",
                                 $time, exp_f.is_error, o_is_error);
                        n_errors++;
                    end
                    if (o_last !== exp_f.last) begin
                        $display("%0t: last expected %b actual %b",
                                 $time, exp_f.last, o_last);
                        n_errors++;
                    end
                end
            end
            if ((i_start && !o_busy) || o_valid) begin
                idle_count = 0;
            end else begin
                idle_count++;
            end
            if (idle_count >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog, no progress for %0d cycles", $time, idle_count);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        int          sel;
        logic [15:0] v;
        // directed: digit range edges, overflow edges, every digit 0-9 in at least one position
        add_word(16'd0, 1'b0);
        add_word(16'd9, 1'b0);
        add_word(16'd10, 1'b0);
        add_word(16'd99, 1'b0);
        add_word(16'd100, 1'b0);
        add_word(16'd999, 1'b0);
        add_word(16'd1000, 1'b0);
        add_word(16'd9999, 1'b0);
        add_word(16'd10000, 1'b1);
        add_word(16'd65535, 1'b0);
        add_word(16'd1234, 1'b0);
        add_word(16'd5678, 1'b0);
        add_word(16'd9012, 1'b0);
        add_word(16'd3456, 1'b0);
        add_word(16'd7890, 1'b0);
        add_word(16'd4321, 1'b0);
        add_word(16'd8888, 1'b0);
        add_word(16'd10001, 1'b0);
        add_word(16'h5555, 1'b0);
        add_word(16'hAAAA, 1'b1);
        add_word(16'd0, 1'b0);
        add_word(16'h8000, 1'b0);
        add_word(16'd7, 1'b0);
        for (int k = 0; k < 400; k++) begin
            sel = $urandom_range(0, 19);
            if (sel < 12) begin
                v = 16'($urandom_range(0, 9999));
            end else if (sel < 15) begin
                v = 16'($urandom_range(9990, 10010));
            end else if (sel < 17) begin
                v = 16'($urandom_range(0, 99));
            end else begin
                v = 16'($urandom);
            end
            add_word(v, (k % 90) == 45);
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_words.size() == 0 && !i_start && frames_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (frames_due.size() != 0) begin
            $display("%0t: %0d frames never arrived", $time, frames_due.size());
            n_errors++;
        end
        $display("run covered %0d values, %0d of them out of range, %0d frames checked",
                 n_values, n_overflow, n_frames);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
